### hw/rtl/median3x3_filter_core_defines.svh
// Assertion macros for the checker file of the median filter core.
`ifndef MEDIAN3X3_FILTER_CORE_DEFINES_SVH
`define MEDIAN3X3_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MF3_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MF3_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/mf3_pkg.sv
package mf3_pkg;

	localparam int MAX_WIDTH  = 128;
	localparam int MAX_HEIGHT = 128;
	localparam int PIX_W      = 8;
	localparam int DIM_W      = 8;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int MIN_DIM    = 3;
	localparam int TAPS       = 9;
	localparam int WIN_REGS   = 6;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int CFG_IDX_W   = 1;
	localparam int OUT_FIELDS_W = PIX_W + COL_W + ROW_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef logic [PIX_W-1:0] pix_t;

	// One 3x3 window with the position of its centre
	typedef struct packed {
		logic [TAPS-1:0][PIX_W-1:0] taps;
		logic [COL_W-1:0]           col;
		logic [ROW_W-1:0]           row;
		logic                       last;
	} win_item_t;

	// Low, middle and high of one sorted triple
	typedef struct packed {
		pix_t lo;
		pix_t md;
		pix_t hi;
	} triple_t;

	typedef struct packed {
		pix_t             median;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             last;
	} result_t;

	function automatic pix_t min2(input pix_t a, input pix_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pix_t max2(input pix_t a, input pix_t b);
		return (a < b) ? b : a;
	endfunction

	function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
		return min2(min2(a, b), c);
	endfunction

	function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
		return max2(max2(a, b), c);
	endfunction

	function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] hi);
		if (v < DIM_W'(MIN_DIM))
			return DIM_W'(MIN_DIM);
		if (v > hi)
			return hi;
		return v;
	endfunction

endpackage

### hw/rtl/mf3_front.sv
module mf3_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            restart,
	input  logic [mf3_pkg::DIM_W-1:0]       frame_w,
	input  logic [mf3_pkg::DIM_W-1:0]       frame_h,
	input  logic                            pix_valid,
	output logic                            pix_ready,
	input  mf3_pkg::pix_t                   pix,
	input  logic [mf3_pkg::QLVL_W-1:0]      q_level,
	output logic                            push,
	output mf3_pkg::win_item_t              push_item
);

	logic [mf3_pkg::COL_W-1:0] col_q;
	logic [mf3_pkg::ROW_W-1:0] row_q;
	logic                      accept;
	logic                      last_col;
	logic                      last_row;

	mf3_pkg::pix_t upper_mem  [mf3_pkg::MAX_WIDTH];
	mf3_pkg::pix_t middle_mem [mf3_pkg::MAX_WIDTH];
	mf3_pkg::pix_t upper_rd_q;
	mf3_pkg::pix_t middle_rd_q;

	logic                      valid_s1;
	mf3_pkg::pix_t             pix_s1;
	logic [mf3_pkg::COL_W-1:0] col_s1;
	logic [mf3_pkg::ROW_W-1:0] row_s1;
	logic                      emit_s1;
	logic                      last_s1;

	mf3_pkg::pix_t win_q [mf3_pkg::WIN_REGS];

	// Room for the item in flight in s1 as well as this one
	assign pix_ready = ((mf3_pkg::QLVL_W + 1)'(q_level) + (mf3_pkg::QLVL_W + 1)'(valid_s1))
		< (mf3_pkg::QLVL_W + 1)'(mf3_pkg::QUEUE_DEPTH);
	assign accept    = pix_valid && pix_ready;
	assign last_col  = (mf3_pkg::DIM_W'(col_q) == frame_w - mf3_pkg::DIM_W'(1));
	assign last_row  = (mf3_pkg::DIM_W'(row_q) == frame_h - mf3_pkg::DIM_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + mf3_pkg::ROW_W'(1);
			end else begin
				col_q <= col_q + mf3_pkg::COL_W'(1);
			end
		end
	end

	// Line store read in s0, write-back in s1; consecutive pixels never share a column
	always_ff @(posedge clk) begin
		if (accept) begin
			upper_rd_q  <= upper_mem[col_q];
			middle_rd_q <= middle_mem[col_q];
		end
		if (valid_s1) begin
			upper_mem[col_s1]  <= middle_rd_q;
			middle_mem[col_s1] <= pix_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= pix;
			col_s1  <= col_q;
			row_s1  <= row_q;
			emit_s1 <= (col_q >= mf3_pkg::COL_W'(2)) && (row_q >= mf3_pkg::ROW_W'(2));
			last_s1 <= last_col && last_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mf3_pkg::WIN_REGS; i++)
				win_q[i] <= '0;
		end else if (restart) begin
			for (int i = 0; i < mf3_pkg::WIN_REGS; i++)
				win_q[i] <= '0;
		end else if (valid_s1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= upper_rd_q;
			win_q[4] <= middle_rd_q;
			win_q[5] <= pix_s1;
		end
	end

	assign push = valid_s1 && emit_s1;

	always_comb begin
		push_item.taps[0] = win_q[0];
		push_item.taps[1] = win_q[3];
		push_item.taps[2] = upper_rd_q;
		push_item.taps[3] = win_q[1];
		push_item.taps[4] = win_q[4];
		push_item.taps[5] = middle_rd_q;
		push_item.taps[6] = win_q[2];
		push_item.taps[7] = win_q[5];
		push_item.taps[8] = pix_s1;
		push_item.col     = col_s1 - mf3_pkg::COL_W'(1);
		push_item.row     = row_s1 - mf3_pkg::ROW_W'(1);
		push_item.last    = last_s1;
	end

endmodule

### hw/rtl/mf3_queue.sv
module mf3_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  mf3_pkg::win_item_t         push_item,
	input  logic                       pop,
	output logic                       head_valid,
	output mf3_pkg::win_item_t         head_item,
	output logic [mf3_pkg::QLVL_W-1:0] level
);

	mf3_pkg::win_item_t         slot_q [mf3_pkg::QUEUE_DEPTH];
	logic [mf3_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [mf3_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [mf3_pkg::QLVL_W-1:0] level_q;
	logic                       do_pop;

	function automatic logic [mf3_pkg::QPTR_W-1:0] ptr_next(
			input logic [mf3_pkg::QPTR_W-1:0] p);
		return (p == mf3_pkg::QPTR_W'(mf3_pkg::QUEUE_DEPTH - 1)) ? '0
			: p + mf3_pkg::QPTR_W'(1);
	endfunction

	assign head_valid = (level_q != '0);
	assign head_item  = slot_q[rd_ptr_q];
	assign level      = level_q;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !do_pop)
				level_q <= level_q + mf3_pkg::QLVL_W'(1);
			else if (do_pop && !push)
				level_q <= level_q - mf3_pkg::QLVL_W'(1);
		end
	end

endmodule

### hw/rtl/mf3_back.sv
module mf3_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  mf3_pkg::win_item_t head_item,
	output logic               pop,
	output logic               res_valid,
	input  logic               res_ready,
	output mf3_pkg::result_t   res
);

	// Stage 1: sort each triple
	logic                      valid_s1;
	mf3_pkg::triple_t [2:0]    tri_s1;
	logic [mf3_pkg::COL_W-1:0] col_s1;
	logic [mf3_pkg::ROW_W-1:0] row_s1;
	logic                      last_s1;

	// Stage 2: max of lows, median of middles, min of highs
	logic                      valid_s2;
	mf3_pkg::pix_t             lo_s2;
	mf3_pkg::pix_t             md_s2;
	mf3_pkg::pix_t             hi_s2;
	logic [mf3_pkg::COL_W-1:0] col_s2;
	logic [mf3_pkg::ROW_W-1:0] row_s2;
	logic                      last_s2;

	logic                      res_valid_q;
	mf3_pkg::result_t          res_q;

	logic ready_out;
	logic ready_s2;
	logic ready_s1;

	assign ready_out = !res_valid_q || res_ready;
	assign ready_s2  = !valid_s2 || ready_out;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign pop       = head_valid && ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (ready_s1)
				valid_s1 <= head_valid;
			if (ready_s2)
				valid_s2 <= valid_s1;
			if (ready_out)
				res_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			for (int g = 0; g < 3; g++) begin
				tri_s1[g].lo <= mf3_pkg::min3(head_item.taps[3*g], head_item.taps[3*g+1],
					head_item.taps[3*g+2]);
				tri_s1[g].md <= mf3_pkg::med3(head_item.taps[3*g], head_item.taps[3*g+1],
					head_item.taps[3*g+2]);
				tri_s1[g].hi <= mf3_pkg::max3(head_item.taps[3*g], head_item.taps[3*g+1],
					head_item.taps[3*g+2]);
			end
			col_s1  <= head_item.col;
			row_s1  <= head_item.row;
			last_s1 <= head_item.last;
		end
		if (valid_s1 && ready_s2) begin
			lo_s2   <= mf3_pkg::max3(tri_s1[0].lo, tri_s1[1].lo, tri_s1[2].lo);
			md_s2   <= mf3_pkg::med3(tri_s1[0].md, tri_s1[1].md, tri_s1[2].md);
			hi_s2   <= mf3_pkg::min3(tri_s1[0].hi, tri_s1[1].hi, tri_s1[2].hi);
			col_s2  <= col_s1;
			row_s2  <= row_s1;
			last_s2 <= last_s1;
		end
		if (valid_s2 && ready_out) begin
			res_q.median <= mf3_pkg::med3(lo_s2, md_s2, hi_s2);
			res_q.col    <= col_s2;
			res_q.row    <= row_s2;
			res_q.last   <= last_s2;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

### hw/rtl/median3x3_filter_core.sv
// 3x3 median filter for 8-bit grayscale frames streamed in raster order. One pixel
// transfer per clock is sustained while results are taken: each line store is read at
// the incoming column and written back the cycle after, one access of each kind per
// cycle, and the median network is a three-stage pipeline that also takes one window
// per cycle unless m_tready stalls it. A pixel at row 2 or later and column 2 or later
// yields one result, the median of the window centred one row up and one column left;
// border pixels yield nothing. A four-entry queue between the window builder and the
// median pipeline lets the output stall without stopping input at once: s_tready
// drops only when the queue plus the pixel in flight would fill it. Writing
// frame_width (index 0) or frame_height (index 1) restarts the frame; values below 3
// are taken as 3 and above 128 as 128. Write configuration only while no results are
// pending. The line stores are not cleared at reset and need no clearing pass: every
// entry that feeds a result is written earlier in the same frame.
module median3x3_filter_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// slave side: [7:0] pixel_in
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [mf3_pkg::PIX_W-1:0]           s_tdata,
	// master side: [7:0] median_value, [14:8] center_col, [21:15] center_row, rest zero
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [mf3_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic                                m_tlast,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [mf3_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mf3_pkg::DIM_W-1:0]           cfg_data
);

	localparam int PAD_W = mf3_pkg::OUT_TDATA_W - mf3_pkg::OUT_FIELDS_W;

	logic [mf3_pkg::DIM_W-1:0]  frame_w_q;
	logic [mf3_pkg::DIM_W-1:0]  frame_h_q;
	logic                       restart;

	logic                       push;
	mf3_pkg::win_item_t         push_item;
	logic                       pop;
	logic                       head_valid;
	mf3_pkg::win_item_t         head_item;
	logic [mf3_pkg::QLVL_W-1:0] q_level;
	mf3_pkg::result_t           res;

	// Any write restarts the frame
	assign restart = cfg_we;

	// Hold the clamped sizes; the clamp is applied once at write time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_w_q <= mf3_pkg::DIM_W'(mf3_pkg::MAX_WIDTH);
			frame_h_q <= mf3_pkg::DIM_W'(mf3_pkg::MAX_HEIGHT);
		end else if (cfg_we) begin
			unique case (mf3_pkg::cfg_reg_t'(cfg_index))
				mf3_pkg::REG_FRAME_WIDTH: begin
					frame_w_q <= mf3_pkg::clamp_dim(cfg_data,
						mf3_pkg::DIM_W'(mf3_pkg::MAX_WIDTH));
				end
				mf3_pkg::REG_FRAME_HEIGHT: begin
					frame_h_q <= mf3_pkg::clamp_dim(cfg_data,
						mf3_pkg::DIM_W'(mf3_pkg::MAX_HEIGHT));
				end
				default: begin
				end
			endcase
		end
	end

	// Front: position counters, line stores and the sliding window
	mf3_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (restart),
		.frame_w   (frame_w_q),
		.frame_h   (frame_h_q),
		.pix_valid (s_tvalid),
		.pix_ready (s_tready),
		.pix       (s_tdata),
		.q_level   (q_level),
		.push      (push),
		.push_item (push_item)
	);

	// Decouple window building from the median pipeline
	mf3_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item),
		.level      (q_level)
	);

	// Back: sort triples, combine, pick the median, hold it until transfer
	mf3_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res        (res)
	);

	assign m_tdata = {{PAD_W{1'b0}}, res.row, res.col, res.median};
	assign m_tlast = res.last;

endmodule

### hw/rtl/mf3_checker.sv
`include "median3x3_filter_core_defines.svh"

module mf3_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [mf3_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                            m_tlast
);

	localparam int COL_LO = mf3_pkg::PIX_W;
	localparam int ROW_LO = mf3_pkg::PIX_W + mf3_pkg::COL_W;

	// A stalled result must not change
	`MF3_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

	// Results only come from interior windows: centre never on row 0 or column 0
	`MF3_ASSERT_NOW(a_interior, m_tvalid,
		(m_tdata[ROW_LO +: mf3_pkg::ROW_W] != '0) && (m_tdata[COL_LO +: mf3_pkg::COL_W] != '0),
		"result centre on frame border")

	// Padding above the packed fields stays zero
	`MF3_ASSERT_NOW(a_pad_zero, m_tvalid,
		m_tdata[mf3_pkg::OUT_TDATA_W-1:mf3_pkg::OUT_FIELDS_W] == '0,
		"tdata padding not zero")

endmodule

bind median3x3_filter_core mf3_checker u_mf3_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
